[sv/gmd_pkg.sv]
// types, constants and helpers shared by the gray morphology disk block
package gmd_pkg;

	localparam int PIX_W = 8;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
	localparam int CFG_W = 11;

	// cell bus widths, sized for the largest supported configuration
	localparam int BUS_COL_W  = 12;
	localparam int BUS_ROW_W  = 13;
	localparam int BUS_SQ_W   = 9;
	localparam int BUS_RING_W = 5;
	localparam int BUS_R_W    = 5;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             flush;
	} gmd_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             row_end;
		logic             frame_end;
	} gmd_out_t;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_RADIUS = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} gmd_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_SWEEP,
		S_SETTLE,
		S_CHAIN,
		S_DONE
	} gmd_state_t;

	// line write into the ring of row cells
	typedef struct packed {
		logic                  en;
		logic [BUS_RING_W-1:0] ring;
		logic [BUS_COL_W-1:0]  col;
		logic [PIX_W-1:0]      pix;
	} gmd_wr_t;

	// window sweep control broadcast to all cells
	typedef struct packed {
		logic                  init;
		logic                  active;
		logic                  chain_en;
		logic                  mode;
		logic [BUS_COL_W-1:0]  col;
		logic                  col_ok;
		logic [BUS_SQ_W-1:0]   dx_sq;
		logic [BUS_SQ_W-1:0]   r_sq;
		logic [BUS_R_W-1:0]    r;
		logic [BUS_RING_W-1:0] out_ring;
		logic [BUS_ROW_W-1:0]  out_row;
		logic [BUS_ROW_W-1:0]  height;
	} gmd_sweep_t;

	// max for dilation, min for erosion
	function automatic logic [PIX_W-1:0] pick(input logic mode, input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		logic [PIX_W-1:0] res;
		if (mode) begin
			res = (a > b) ? a : b;
		end else begin
			res = (a < b) ? a : b;
		end
		return res;
	endfunction

	function automatic logic [PIX_W-1:0] identity(input logic mode);
		return mode ? '0 : PIX_MAX;
	endfunction

endpackage

[sv/gray_morph_disk.sv]
// top level of the streaming gray erosion / dilation with a disk element
//
// pixels of a frame come in raster order on the in channel (valid/ready),
// one item per pixel; after the last pixel, flush items drain the results
// that are still pending. results leave on the out channel in raster order
// with row_end and frame_end marks. mode, radius, width and height are
// written through the plain write port and take effect at a frame's first
// pixel. the line store is a ring of 2*MAX_RADIUS+2 row cells; each cell
// owns one line memory and a running min/max for its row.
// an item that gives no result is taken in the idle state. an item that
// gives a result is worked in steps: the accept, a setup, a sweep over
// 2*r+1 columns (one read of every row cell per cycle), a settle step, the
// travel of the value down the chain of 2*MAX_RADIUS+2 cells and the load
// of the output register. the result of pixel k leaves with the item
// r*W + min(r, W-1) items later.
// a finished result waits in the output register; if the receiver stalls,
// the next item is still taken and its result waits until the register
// frees. reset clears counters, state and the output valid flag and sets the
// registers to erosion, radius 1, 1024 x 1024; line memories are not
// cleared and need no clearing, every pixel read is written first.
module gray_morph_disk import gmd_pkg::*; #(
	parameter int MAX_RADIUS = 7,
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gmd_in_t          in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output gmd_out_t         out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int NROWS = 2 * MAX_RADIUS + 2;
	localparam int NGW   = $clog2(NROWS);
	localparam int RW    = $clog2(MAX_RADIUS + 2);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CLW   = $clog2(MAX_WIDTH);
	localparam int CW    = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_RADIUS + 1) + 1);
	localparam int KW    = $clog2(NROWS + 1);

	// configuration registers
	logic             cfg_mode_q;
	logic [2:0]       cfg_radius_q;
	logic [CFG_W-1:0] cfg_width_q;
	logic [CFG_W-1:0] cfg_height_q;

	// values latched for the running frame
	logic          act_mode_q;
	logic [RW-1:0] act_r_q;
	logic [WW-1:0] act_w_q;
	logic [HW-1:0] act_h_q;

	// frame position
	logic [CW-1:0]  cnt_q;
	logic [CLW-1:0] in_col_q;
	logic [HW-1:0]  in_row_q;
	logic [NGW-1:0] in_ring_q;
	logic [CLW-1:0] ocol_q;
	logic [HW-1:0]  orow_q;
	logic [NGW-1:0] out_ring_q;

	gmd_state_t state_q, state_d;
	logic signed [RW:0] dx_q;
	logic [KW-1:0]      chn_q;
	logic               out_valid_q;
	gmd_out_t           out_q;

	logic          first;
	logic          sel_mode;
	logic [RW-1:0] sel_r;
	logic [WW-1:0] sel_w;
	logic [HW-1:0] sel_h;
	logic [CW-1:0] delay;
	logic          in_fire;
	logic          in_more;
	logic          ignore;
	logic          compute;
	logic          do_write;
	logic          load;
	logic          rend;
	logic          fend;

	logic signed [CLW+1:0] vx;
	logic                  col_ok;
	logic [RW-1:0]         dx_abs;
	logic [2*RW-1:0]       dx_sq_full;
	logic [2*RW-1:0]       r_sq_full;

	gmd_wr_t          wr;
	gmd_sweep_t       sw;
	logic [PIX_W-1:0] links [NROWS+1];

	function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
		logic [WW-1:0] res;
		if (v == '0) begin
			res = WW'(1);
		end else if (32'(v) > MAX_WIDTH) begin
			res = WW'(MAX_WIDTH);
		end else begin
			res = WW'(v);
		end
		return res;
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
		logic [HW-1:0] res;
		if (v == '0) begin
			res = HW'(1);
		end else if (32'(v) > MAX_HEIGHT) begin
			res = HW'(MAX_HEIGHT);
		end else begin
			res = HW'(v);
		end
		return res;
	endfunction

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode_q   <= 1'b0;
			cfg_radius_q <= 3'd1;
			cfg_width_q  <= CFG_W'(1024);
			cfg_height_q <= CFG_W'(1024);
		end else if (cfg_we) begin
			unique case (gmd_reg_t'(cfg_index))
				REG_MODE:   cfg_mode_q   <= cfg_data[0];
				REG_RADIUS: cfg_radius_q <= cfg_data[2:0];
				REG_WIDTH:  cfg_width_q  <= cfg_data;
				REG_HEIGHT: cfg_height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// a frame's first pixel takes the register values, later items the latched ones
	always_comb begin
		first = (cnt_q == '0);
		if (first) begin
			sel_mode = cfg_mode_q;
			sel_r    = (32'(cfg_radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_radius_q);
			sel_w    = clamp_w(cfg_width_q);
			sel_h    = clamp_h(cfg_height_q);
		end else begin
			sel_mode = act_mode_q;
			sel_r    = act_r_q;
			sel_w    = act_w_q;
			sel_h    = act_h_q;
		end
		// output lags input by r rows plus r columns, columns clipped to the row
		if ((WW+1)'(sel_r) < (WW+1)'(sel_w) - (WW+1)'(1)) begin
			delay = CW'(sel_r) * CW'(sel_w) + CW'(sel_r);
		end else begin
			delay = CW'(sel_r) * CW'(sel_w) + CW'(sel_w) - CW'(1);
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign in_more  = (in_row_q < sel_h);
	assign ignore   = in_data.flush && (first || in_more);
	assign do_write = in_fire && !ignore && in_more;
	assign compute  = in_fire && !ignore && (cnt_q >= delay);

	// result marks at the output position
	assign rend = ((WW+1)'(ocol_q) + (WW+1)'(1)) >= (WW+1)'(act_w_q);
	assign fend = rend && (((HW+1)'(orow_q) + (HW+1)'(1)) >= (HW+1)'(act_h_q));
	assign load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// column sweep over dx
	always_comb begin
		vx         = ($signed({2'b00, ocol_q})) + (CLW+2)'(dx_q);
		col_ok     = (vx >= 0) && (vx < $signed((CLW+2)'(act_w_q)));
		dx_abs     = (dx_q < 0) ? RW'(-dx_q) : RW'(dx_q);
		dx_sq_full = (2*RW)'(dx_abs) * (2*RW)'(dx_abs);
		r_sq_full  = (2*RW)'(act_r_q) * (2*RW)'(act_r_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (compute) state_d = S_INIT;
			S_INIT:   state_d = S_SWEEP;
			S_SWEEP:  if (dx_q == $signed({1'b0, act_r_q})) state_d = S_SETTLE;
			S_SETTLE: state_d = S_CHAIN;
			S_CHAIN:  if (chn_q == KW'(NROWS - 1)) state_d = S_DONE;
			S_DONE:   if (load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// frame counters and latched configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode_q  <= 1'b0;
			act_r_q     <= RW'(1);
			act_w_q     <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
			act_h_q     <= HW'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);
			cnt_q       <= '0;
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_ring_q   <= '0;
			ocol_q      <= '0;
			orow_q      <= '0;
			out_ring_q  <= '0;
			dx_q        <= '0;
			chn_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire && !ignore) begin
				cnt_q <= cnt_q + CW'(1);
				if (first) begin
					act_mode_q <= sel_mode;
					act_r_q    <= sel_r;
					act_w_q    <= sel_w;
					act_h_q    <= sel_h;
				end
			end
			if (do_write) begin
				if (((WW+1)'(in_col_q) + (WW+1)'(1)) >= (WW+1)'(sel_w)) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + HW'(1);
					in_ring_q <= (in_ring_q == NGW'(NROWS - 1)) ? '0 : in_ring_q + NGW'(1);
				end else begin
					in_col_q <= in_col_q + CLW'(1);
				end
			end
			if (state_q == S_INIT) begin
				dx_q <= -$signed({1'b0, act_r_q});
			end else if (state_q == S_SWEEP) begin
				dx_q <= dx_q + (RW+1)'(1);
			end
			if (state_q == S_CHAIN) begin
				chn_q <= chn_q + KW'(1);
			end else begin
				chn_q <= '0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				if (fend) begin
					cnt_q      <= '0;
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_ring_q  <= '0;
					ocol_q     <= '0;
					orow_q     <= '0;
					out_ring_q <= '0;
				end else if (rend) begin
					ocol_q     <= '0;
					orow_q     <= orow_q + HW'(1);
					out_ring_q <= (out_ring_q == NGW'(NROWS - 1)) ? '0 : out_ring_q + NGW'(1);
				end else begin
					ocol_q <= ocol_q + CLW'(1);
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.pixel_out <= links[NROWS];
			out_q.row_end   <= rend;
			out_q.frame_end <= fend;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// broadcast to the cell row
	always_comb begin
		wr.en   = do_write;
		wr.ring = BUS_RING_W'(in_ring_q);
		wr.col  = BUS_COL_W'(in_col_q);
		wr.pix  = in_data.pixel_in;

		sw.init     = (state_q == S_INIT);
		sw.active   = (state_q == S_SWEEP);
		sw.chain_en = (state_q == S_CHAIN);
		sw.mode     = act_mode_q;
		sw.col      = BUS_COL_W'(vx[CLW-1:0]);
		sw.col_ok   = col_ok;
		sw.dx_sq    = BUS_SQ_W'(dx_sq_full);
		sw.r_sq     = BUS_SQ_W'(r_sq_full);
		sw.r        = BUS_R_W'(act_r_q);
		sw.out_ring = BUS_RING_W'(out_ring_q);
		sw.out_row  = BUS_ROW_W'(orow_q);
		sw.height   = BUS_ROW_W'(act_h_q);
	end

	// chain head feeds the neutral value
	assign links[0] = identity(act_mode_q);

	for (genvar i = 0; i < NROWS; i++) begin : g_cell
		gmd_cell #(
			.ROW       (i),
			.NROWS     (NROWS),
			.MAX_WIDTH (MAX_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr       (wr),
			.sw       (sw),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	// no item taken while a window is being worked
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("item accepted while busy");

	// a stalled result is kept
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result lost");

	// frame end clears the item count
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(load && fend) |=> (cnt_q == '0))
		else $error("frame count not cleared");

	// ring pointers stay inside the ring
	a_ring_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(in_ring_q) < NROWS) && (32'(out_ring_q) < NROWS))
		else $error("ring pointer out of range");

endmodule

[sv/gmd_cell.sv]
// one row cell: a line of pixels, its partial window result and a chain link
module gmd_cell import gmd_pkg::*; #(
	parameter int ROW       = 0,
	parameter int NROWS     = 16,
	parameter int MAX_WIDTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gmd_wr_t          wr,
	input  gmd_sweep_t       sw,
	input  logic [PIX_W-1:0] link_in,
	output logic [PIX_W-1:0] link_out
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [PIX_W-1:0] mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_s1;
	logic             take_s1;
	logic             row_ok_q;
	logic [BUS_SQ_W-1:0] dy_sq_q;
	logic [PIX_W-1:0] acc_q;
	logic [PIX_W-1:0] link_q;

	logic [5:0]          ring_dist;
	logic [4:0]          dy_mag;
	logic                row_ok;
	logic [9:0]          dy_sq_full;
	logic                take;

	// distance of this ring row from the output row, both directions
	always_comb begin
		if (6'(ROW) >= {1'b0, sw.out_ring}) begin
			ring_dist = 6'(ROW) - {1'b0, sw.out_ring};
		end else begin
			ring_dist = 6'(ROW) + 6'(NROWS) - {1'b0, sw.out_ring};
		end
		dy_mag = '0;
		row_ok = 1'b0;
		if (ring_dist <= {1'b0, sw.r}) begin
			dy_mag = ring_dist[4:0];
			row_ok = (sw.out_row + 13'(ring_dist)) < sw.height;
		end else if (ring_dist >= 6'(NROWS) - {1'b0, sw.r}) begin
			dy_mag = 5'(6'(NROWS) - ring_dist);
			row_ok = sw.out_row >= 13'(dy_mag);
		end
		dy_sq_full = 10'(dy_mag) * 10'(dy_mag);
	end

	assign take = sw.active && sw.col_ok && row_ok_q
		&& (({1'b0, sw.dx_sq} + {1'b0, dy_sq_q}) <= {1'b0, sw.r_sq});

	always_ff @(posedge clk) begin
		if (wr.en && (wr.ring == BUS_RING_W'(ROW))) begin
			mem[wr.col[AW-1:0]] <= wr.pix;
		end
		rd_s1 <= mem[sw.col[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1  <= 1'b0;
			row_ok_q <= 1'b0;
		end else begin
			take_s1 <= take;
			if (sw.init) begin
				row_ok_q <= row_ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sw.init) begin
			dy_sq_q <= dy_sq_full[BUS_SQ_W-1:0];
			acc_q   <= identity(sw.mode);
		end else if (take_s1) begin
			acc_q <= pick(sw.mode, acc_q, rd_s1);
		end
		if (sw.chain_en) begin
			link_q <= pick(sw.mode, link_in, acc_q);
		end
	end

	assign link_out = link_q;

endmodule
